// ===== rtl/assert_macros.svh =====
// Assertion helper macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define ASSERT_IMPLY(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");

// Implication whose consequent is checked in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");

`endif

// ===== rtl/sha512c_pkg.sv =====
// ---------------------------------------------------------------------------
// SHA-512 compression package
// Types, round constants and the sigma functions shared by the block.
// ---------------------------------------------------------------------------
package sha512c_pkg;

    typedef logic [63:0] word_t;

    // Action codes of an input request.
    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_MSG  = 1'b1;

    localparam int ROUNDS = 80;

    // Request handed from the front part to the compression engine.
    typedef struct packed {
        logic  is_msg;
        logic  start;
        word_t data;
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ROUND,
        ST_ADD,
        ST_OUT
    } eng_state_t;

    function automatic word_t rotr(input word_t x, input int unsigned amt);
        rotr = (x >> amt) | (x << (64 - amt));
    endfunction

    function automatic word_t big_sigma0(input word_t x);
        big_sigma0 = rotr(x, 28) ^ rotr(x, 34) ^ rotr(x, 39);
    endfunction

    function automatic word_t big_sigma1(input word_t x);
        big_sigma1 = rotr(x, 14) ^ rotr(x, 18) ^ rotr(x, 41);
    endfunction

    function automatic word_t small_sigma0(input word_t x);
        small_sigma0 = rotr(x, 1) ^ rotr(x, 8) ^ (x >> 7);
    endfunction

    function automatic word_t small_sigma1(input word_t x);
        small_sigma1 = rotr(x, 19) ^ rotr(x, 61) ^ (x >> 6);
    endfunction

    // Standard SHA-512 round constant ROM.
    function automatic word_t round_k(input logic [6:0] idx);
        word_t k;
        case (idx)
            7'd0: k = 64'h428a2f98d728ae22;  7'd1: k = 64'h7137449123ef65cd;
            7'd2: k = 64'hb5c0fbcfec4d3b2f;  7'd3: k = 64'he9b5dba58189dbbc;
            7'd4: k = 64'h3956c25bf348b538;  7'd5: k = 64'h59f111f1b605d019;
            7'd6: k = 64'h923f82a4af194f9b;  7'd7: k = 64'hab1c5ed5da6d8118;
            7'd8: k = 64'hd807aa98a3030242;  7'd9: k = 64'h12835b0145706fbe;
            7'd10: k = 64'h243185be4ee4b28c; 7'd11: k = 64'h550c7dc3d5ffb4e2;
            7'd12: k = 64'h72be5d74f27b896f; 7'd13: k = 64'h80deb1fe3b1696b1;
            7'd14: k = 64'h9bdc06a725c71235; 7'd15: k = 64'hc19bf174cf692694;
            7'd16: k = 64'he49b69c19ef14ad2; 7'd17: k = 64'hefbe4786384f25e3;
            7'd18: k = 64'h0fc19dc68b8cd5b5; 7'd19: k = 64'h240ca1cc77ac9c65;
            7'd20: k = 64'h2de92c6f592b0275; 7'd21: k = 64'h4a7484aa6ea6e483;
            7'd22: k = 64'h5cb0a9dcbd41fbd4; 7'd23: k = 64'h76f988da831153b5;
            7'd24: k = 64'h983e5152ee66dfab; 7'd25: k = 64'ha831c66d2db43210;
            7'd26: k = 64'hb00327c898fb213f; 7'd27: k = 64'hbf597fc7beef0ee4;
            7'd28: k = 64'hc6e00bf33da88fc2; 7'd29: k = 64'hd5a79147930aa725;
            7'd30: k = 64'h06ca6351e003826f; 7'd31: k = 64'h142929670a0e6e70;
            7'd32: k = 64'h27b70a8546d22ffc; 7'd33: k = 64'h2e1b21385c26c926;
            7'd34: k = 64'h4d2c6dfc5ac42aed; 7'd35: k = 64'h53380d139d95b3df;
            7'd36: k = 64'h650a73548baf63de; 7'd37: k = 64'h766a0abb3c77b2a8;
            7'd38: k = 64'h81c2c92e47edaee6; 7'd39: k = 64'h92722c851482353b;
            7'd40: k = 64'ha2bfe8a14cf10364; 7'd41: k = 64'ha81a664bbc423001;
            7'd42: k = 64'hc24b8b70d0f89791; 7'd43: k = 64'hc76c51a30654be30;
            7'd44: k = 64'hd192e819d6ef5218; 7'd45: k = 64'hd69906245565a910;
            7'd46: k = 64'hf40e35855771202a; 7'd47: k = 64'h106aa07032bbd1b8;
            7'd48: k = 64'h19a4c116b8d2d0c8; 7'd49: k = 64'h1e376c085141ab53;
            7'd50: k = 64'h2748774cdf8eeb99; 7'd51: k = 64'h34b0bcb5e19b48a8;
            7'd52: k = 64'h391c0cb3c5c95a63; 7'd53: k = 64'h4ed8aa4ae3418acb;
            7'd54: k = 64'h5b9cca4f7763e373; 7'd55: k = 64'h682e6ff3d6b2b8a3;
            7'd56: k = 64'h748f82ee5defb2fc; 7'd57: k = 64'h78a5636f43172f60;
            7'd58: k = 64'h84c87814a1f0ab72; 7'd59: k = 64'h8cc702081a6439ec;
            7'd60: k = 64'h90befffa23631e28; 7'd61: k = 64'ha4506cebde82bde9;
            7'd62: k = 64'hbef9a3f7b2c67915; 7'd63: k = 64'hc67178f2e372532b;
            7'd64: k = 64'hca273eceea26619c; 7'd65: k = 64'hd186b8c721c0c207;
            7'd66: k = 64'heada7dd6cde0eb1e; 7'd67: k = 64'hf57d4f7fee6ed178;
            7'd68: k = 64'h06f067aa72176fba; 7'd69: k = 64'h0a637dc5a2c898a6;
            7'd70: k = 64'h113f9804bef90dae; 7'd71: k = 64'h1b710b35131c471b;
            7'd72: k = 64'h28db77f523047d84; 7'd73: k = 64'h32caab7b40c72493;
            7'd74: k = 64'h3c9ebe0a15c9bebc; 7'd75: k = 64'h431d67c49c100d4c;
            7'd76: k = 64'h4cc5d4becb3e42b6; 7'd77: k = 64'h597f299cfc657e2a;
            7'd78: k = 64'h5fcb6fab3ad6faec; 7'd79: k = 64'h6c44198c4a475817;
            default: k = '0;
        endcase
        round_k = k;
    endfunction

endpackage

// ===== rtl/sha512c_if.sv =====
// ---------------------------------------------------------------------------
// SHA-512 stream interfaces
// Valid/ready channels for input requests and hash words.
// ---------------------------------------------------------------------------
interface sha512c_in_if;
    logic        valid;
    logic        ready;
    logic        action;
    logic [63:0] data_word;

    modport source (output valid, output action, output data_word, input ready);
    modport sink (input valid, input action, input data_word, output ready);
endinterface

interface sha512c_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] hash_word;
    logic [2:0]  word_number;
    logic        last_word;

    modport source (output valid, output hash_word, output word_number,
                    output last_word, input ready);
    modport sink (input valid, input hash_word, input word_number,
                  input last_word, output ready);
endinterface

// ===== rtl/sha512c_front.sv =====
// ---------------------------------------------------------------------------
// SHA-512 front part
// Accepts requests, tracks the message slot and marks the block-ending word.
// ---------------------------------------------------------------------------
module sha512c_front
    import sha512c_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    sha512c_in_if.sink in_ch,
    output logic  cmd_valid,
    input  logic  cmd_ready,
    output cmd_t  cmd
);

    logic [3:0] msg_cnt_reg;
    logic [3:0] msg_cnt_next;

    assign in_ch.ready   = cmd_ready;
    assign cmd_valid     = in_ch.valid;
    assign cmd.is_msg    = (in_ch.action == ACT_MSG);
    assign cmd.start     = (in_ch.action == ACT_MSG) && (msg_cnt_reg == 4'd15);
    assign cmd.data      = in_ch.data_word;

    // Next message slot, wrapping after sixteen words.
    always_comb
    begin
        msg_cnt_next = msg_cnt_reg;
        if (in_ch.valid && cmd_ready && in_ch.action == ACT_MSG)
        begin
            msg_cnt_next = msg_cnt_reg + 4'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            msg_cnt_reg <= '0;
        end
        else
        begin
            msg_cnt_reg <= msg_cnt_next;
        end
    end

endmodule

// ===== rtl/sha512c_fifo.sv =====
// ---------------------------------------------------------------------------
// SHA-512 request queue
// Two-entry queue between the front part and the compression engine.
// ---------------------------------------------------------------------------
module sha512c_fifo
    import sha512c_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push_valid,
    output logic push_ready,
    input  cmd_t push_cmd,
    output logic pop_valid,
    input  logic pop_ready,
    output cmd_t pop_cmd
);

    `include "assert_macros.svh"

    cmd_t       mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       push;
    logic       pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_cmd    = mem_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    `ASSERT_IMPLY(a_count_range, clk, rst_n, 1'b1, count_reg <= 2'd2)
    `ASSERT_IMPLY(a_ptr_match, clk, rst_n, count_reg == 2'd0 || count_reg == 2'd2,
        wr_ptr_reg == rd_ptr_reg)

endmodule

// ===== rtl/sha512c_engine.sv =====
// ---------------------------------------------------------------------------
// SHA-512 compression engine
// Stores chaining and message words, runs the rounds and emits hash words.
// ---------------------------------------------------------------------------
module sha512c_engine
    import sha512c_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic cmd_valid,
    output logic cmd_ready,
    input  cmd_t cmd,
    sha512c_out_if.source out_ch
);

    `include "assert_macros.svh"

    eng_state_t state_reg;
    eng_state_t state_next;

    word_t      chain_reg [8];
    word_t      var_reg [8];
    word_t      win_reg [16];
    logic [2:0] load_cnt_reg;
    logic [3:0] msg_cnt_reg;
    logic [6:0] round_reg;
    logic [2:0] out_idx_reg;

    logic       take;
    logic       round_en;
    logic       add_en;
    word_t      t1;
    word_t      t2;
    word_t      ch_val;
    word_t      maj_val;
    word_t      w_new;
    logic [3:0] slot;

    // Round datapath.
    assign slot    = round_reg[3:0];
    assign ch_val  = (var_reg[4] & var_reg[5]) ^ (~var_reg[4] & var_reg[6]);
    assign maj_val = (var_reg[0] & var_reg[1]) ^ (var_reg[0] & var_reg[2])
                   ^ (var_reg[1] & var_reg[2]);
    assign t1      = var_reg[7] + big_sigma1(var_reg[4]) + ch_val
                   + round_k(round_reg) + win_reg[slot];
    assign t2      = big_sigma0(var_reg[0]) + maj_val;

    // Schedule word refreshed in place as each slot is consumed.
    assign w_new   = win_reg[slot] + win_reg[slot + 4'd9]
                   + small_sigma0(win_reg[slot + 4'd1])
                   + small_sigma1(win_reg[slot + 4'd14]);

    assign out_ch.hash_word   = chain_reg[out_idx_reg];
    assign out_ch.word_number = out_idx_reg;
    assign out_ch.last_word   = (out_idx_reg == 3'd7);

    // Control state machine.
    always_comb
    begin
        state_next = state_reg;
        cmd_ready  = 1'b0;
        out_ch.valid = 1'b0;
        round_en   = 1'b0;
        add_en     = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd_ready = 1'b1;
                if (cmd_valid && cmd.start)
                begin
                    state_next = ST_ROUND;
                end
            end
            ST_ROUND:
            begin
                round_en = 1'b1;
                if (round_reg == 7'(ROUNDS - 1))
                begin
                    state_next = ST_ADD;
                end
            end
            ST_ADD:
            begin
                add_en     = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                out_ch.valid = 1'b1;
                if (out_ch.ready && out_idx_reg == 3'd7)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign take = cmd_valid && cmd_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            load_cnt_reg <= '0;
            msg_cnt_reg  <= '0;
            round_reg    <= '0;
            out_idx_reg  <= '0;
            for (int i = 0; i < 8; i++)
            begin
                chain_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (take && !cmd.is_msg)
            begin
                chain_reg[load_cnt_reg] <= cmd.data;
                load_cnt_reg <= load_cnt_reg + 3'd1;
            end
            if (take && cmd.is_msg)
            begin
                msg_cnt_reg <= msg_cnt_reg + 4'd1;
            end
            if (round_en)
            begin
                round_reg <= (round_reg == 7'(ROUNDS - 1)) ? 7'd0 : round_reg + 7'd1;
            end
            if (add_en)
            begin
                for (int i = 0; i < 8; i++)
                begin
                    chain_reg[i] <= chain_reg[i] + var_reg[i];
                end
            end
            if (out_ch.valid && out_ch.ready)
            begin
                out_idx_reg <= out_idx_reg + 3'd1;
            end
        end
    end

    // Working variables and schedule window.
    always_ff @(posedge clk)
    begin
        if (take && cmd.is_msg)
        begin
            win_reg[msg_cnt_reg] <= cmd.data;
        end
        if (take && cmd.start)
        begin
            for (int i = 0; i < 8; i++)
            begin
                var_reg[i] <= chain_reg[i];
            end
        end
        if (round_en)
        begin
            var_reg[7] <= var_reg[6];
            var_reg[6] <= var_reg[5];
            var_reg[5] <= var_reg[4];
            var_reg[4] <= var_reg[3] + t1;
            var_reg[3] <= var_reg[2];
            var_reg[2] <= var_reg[1];
            var_reg[1] <= var_reg[0];
            var_reg[0] <= t1 + t2;
            win_reg[slot] <= w_new;
        end
    end

    `ASSERT_IMPLY(a_round_idle, clk, rst_n, state_reg == ST_IDLE, round_reg == 7'd0)
    `ASSERT_NEXT(a_start_round, clk, rst_n, take && cmd.start, state_reg == ST_ROUND)
    `ASSERT_IMPLY(a_out_idx_zero, clk, rst_n, state_reg != ST_OUT, out_idx_reg == 3'd0)

endmodule

// ===== rtl/sha512_block_compression.sv =====
// A chaining or non-final message request goes through the request queue and is applied
// when the idle engine takes it. The sixteenth message word starts the 80 rounds, one
// round per cycle in the shared round unit, then the add state, then 8 hash words, one
// per cycle while out_ch.ready is high; no new request is taken until the last is sent.
// Reset: rst_n clears the chaining words and all counters asynchronously.
// ---------------------------------------------------------------------------
// SHA-512 block compression
// Front part, request queue and compression engine.
// ---------------------------------------------------------------------------
module sha512_block_compression
    import sha512c_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    sha512c_in_if.sink    in_ch,
    sha512c_out_if.source out_ch
);

    logic cmd_valid;
    logic cmd_ready;
    cmd_t cmd;
    logic eng_valid;
    logic eng_ready;
    cmd_t eng_cmd;

    sha512c_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    sha512c_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (cmd_valid),
        .push_ready (cmd_ready),
        .push_cmd   (cmd),
        .pop_valid  (eng_valid),
        .pop_ready  (eng_ready),
        .pop_cmd    (eng_cmd)
    );

    sha512c_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (eng_valid),
        .cmd_ready (eng_ready),
        .cmd       (eng_cmd),
        .out_ch    (out_ch)
    );

endmodule
